[rtl/core/dlp_pkg.sv]
// Shared types and constants of the decimal list parser.
// Used by dlp_parse_core, dlp_out_queue and decimal_int16_list_parser.
package dlp_pkg;

  // Fixed limits of the number syntax.
  localparam int MAX_VALUES           = 16;
  localparam int MAX_DIGITS           = 5;
  localparam int DEF_MAX_STRING_BYTES = 2048;

  // Largest number count a string can reach: one past the smaller of the
  // register range and the value limit.
  localparam int MAX_CAP = (MAX_VALUES < 31) ? MAX_VALUES : 31;
  localparam int CNT_W   = $clog2(MAX_CAP + 2);

  localparam logic [19:0] LIMIT_SIGNED   = 20'd32767;
  localparam logic [19:0] LIMIT_UNSIGNED = 20'd65535;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Configuration register indexes.
  localparam logic REG_EXPECTED_COUNT = 1'b0;
  localparam logic REG_SIGNED_MODE    = 1'b1;

  // Result kinds.
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // One input beat causes at most this many results.
  localparam int MAX_RESULTS = 2;

  // Result queue depth, a power of two.
  localparam int OQ_DEPTH = 4;

  typedef struct packed {
    logic [4:0] expected_count;
    logic       signed_mode;
  } cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [3:0]  value_index;
    logic [15:0] value_word;
    logic        parse_status;
    logic [4:0]  values_found;
    logic        last_result;
  } res_t;

endpackage

[rtl/core/dlp_parse_core.sv]
// Per-string parse state and the one-beat next-state logic of the parser.
// Depends on dlp_pkg for the configuration and result types.
module dlp_parse_core #(
  parameter int MAX_STRING_BYTES = dlp_pkg::DEF_MAX_STRING_BYTES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dlp_pkg::cfg_t cfg,
  input  logic          fire,
  input  logic [7:0]    char_byte,
  input  logic          end_of_string,
  output logic [1:0]    push_cnt,
  output dlp_pkg::res_t res_a,
  output dlp_pkg::res_t res_b
);

  localparam int BC_W  = $clog2(MAX_STRING_BYTES + 1);
  localparam int CNT_W = dlp_pkg::CNT_W;

  logic             in_num_r, in_num_nxt;
  logic             minus_r, minus_nxt;
  logic [2:0]       dc_r, dc_nxt;
  logic [15:0]      mag_r, mag_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BC_W-1:0]  bc_r, bc_nxt;
  logic             stop_r, stop_nxt;
  logic             err_r, err_nxt;

  logic             val_vld;
  logic [15:0]      em_mag;
  logic             em_neg;
  logic [CNT_W-1:0] em_cnt;
  dlp_pkg::res_t    val_res;
  dlp_pkg::res_t    sts_res;

  always_comb begin
    logic             is_digit;
    logic             is_space;
    logic             ok;
    logic [CNT_W-1:0] cap;
    logic [19:0]      limit;
    logic [19:0]      prod;
    logic [3:0]       dval;

    in_num_nxt = in_num_r;
    minus_nxt  = minus_r;
    dc_nxt     = dc_r;
    mag_nxt    = mag_r;
    cnt_nxt    = cnt_r;
    bc_nxt     = bc_r;
    stop_nxt   = stop_r;
    err_nxt    = err_r;
    val_vld    = 1'b0;
    em_mag     = mag_r;
    em_neg     = minus_r;
    em_cnt     = cnt_r;
    ok         = 1'b1;

    is_digit = char_byte inside {[dlp_pkg::CHAR_ZERO:dlp_pkg::CHAR_NINE]};
    is_space = (char_byte == dlp_pkg::CHAR_SPACE) ||
               (char_byte inside {[dlp_pkg::CHAR_TAB:dlp_pkg::CHAR_CR]});
    dval     = 4'(char_byte - dlp_pkg::CHAR_ZERO);
    cap      = ({{(CNT_W-5){1'b0}}, cfg.expected_count} < CNT_W'(dlp_pkg::MAX_VALUES)) ?
               {{(CNT_W-5){1'b0}}, cfg.expected_count} : CNT_W'(dlp_pkg::MAX_VALUES);
    limit    = cfg.signed_mode ? dlp_pkg::LIMIT_SIGNED : dlp_pkg::LIMIT_UNSIGNED;
    prod     = '0;

    // Length check comes first; the overflowing byte itself is not parsed.
    if (!stop_nxt) begin
      if (bc_r < BC_W'(MAX_STRING_BYTES)) begin
        bc_nxt = bc_r + 1'b1;
      end else begin
        err_nxt  = 1'b1;
        stop_nxt = 1'b1;
      end
    end

    if (!stop_nxt) begin
      if (is_digit) begin
        if (!in_num_r) begin
          in_num_nxt = 1'b1;
          dc_nxt     = '0;
          mag_nxt    = '0;
          cnt_nxt    = cnt_r + 1'b1;
          if (cnt_nxt > cap) begin
            err_nxt  = 1'b1;
            stop_nxt = 1'b1;
            ok       = 1'b0;
          end
        end
        if (ok) begin
          dc_nxt = dc_nxt + 1'b1;
          prod   = {1'b0, mag_nxt, 3'b000} + {3'b000, mag_nxt, 1'b0} + {16'd0, dval};
          if ((dc_nxt > 3'(dlp_pkg::MAX_DIGITS)) || (prod > limit)) begin
            err_nxt  = 1'b1;
            stop_nxt = 1'b1;
          end else begin
            mag_nxt = prod[15:0];
          end
        end
      end else if (is_space) begin
        if (cfg.signed_mode && !in_num_r && minus_r) begin
          // A lone minus ends parsing; the count check alone judges it.
          stop_nxt = 1'b1;
        end else begin
          if (in_num_r) begin
            val_vld = 1'b1;
          end
          in_num_nxt = 1'b0;
          minus_nxt  = 1'b0;
        end
      end else if (cfg.signed_mode && (char_byte == dlp_pkg::CHAR_MINUS) &&
                   !in_num_r && !minus_r) begin
        minus_nxt = 1'b1;
      end else begin
        err_nxt  = 1'b1;
        stop_nxt = 1'b1;
      end
    end

    // A number still open at the end of the string closes with it.
    if (end_of_string && !stop_nxt && in_num_nxt) begin
      val_vld = 1'b1;
      em_mag  = mag_nxt;
      em_neg  = minus_nxt;
      em_cnt  = cnt_nxt;
    end
  end

  always_comb begin
    logic [CNT_W-1:0] idx_full;
    idx_full             = em_cnt - 1'b1;
    val_res.item_kind    = dlp_pkg::KIND_VALUE;
    val_res.value_index  = idx_full[3:0];
    val_res.value_word   = (cfg.signed_mode && em_neg) ? (16'd0 - em_mag) : em_mag;
    val_res.parse_status = 1'b0;
    val_res.values_found = '0;
    val_res.last_result  = 1'b0;

    sts_res.item_kind    = dlp_pkg::KIND_STATUS;
    sts_res.value_index  = '0;
    sts_res.value_word   = '0;
    sts_res.parse_status = err_nxt || (cnt_nxt != CNT_W'(cfg.expected_count));
    sts_res.values_found = 5'(cnt_nxt);
    sts_res.last_result  = 1'b1;
  end

  // The value result always precedes the status result of the same beat.
  assign res_a    = val_vld ? val_res : sts_res;
  assign res_b    = sts_res;
  assign push_cnt = fire ? (2'(val_vld) + 2'(end_of_string)) : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_num_r <= 1'b0;
      minus_r  <= 1'b0;
      dc_r     <= '0;
      mag_r    <= '0;
      cnt_r    <= '0;
      bc_r     <= '0;
      stop_r   <= 1'b0;
      err_r    <= 1'b0;
    end else if (fire) begin
      if (end_of_string) begin
        in_num_r <= 1'b0;
        minus_r  <= 1'b0;
        dc_r     <= '0;
        mag_r    <= '0;
        cnt_r    <= '0;
        bc_r     <= '0;
        stop_r   <= 1'b0;
        err_r    <= 1'b0;
      end else begin
        in_num_r <= in_num_nxt;
        minus_r  <= minus_nxt;
        dc_r     <= dc_nxt;
        mag_r    <= mag_nxt;
        cnt_r    <= cnt_nxt;
        bc_r     <= bc_nxt;
        stop_r   <= stop_nxt;
        err_r    <= err_nxt;
      end
    end
  end

endmodule

[rtl/core/dlp_out_queue.sv]
// Small result queue: takes up to two results a cycle, gives one while rd_ready is high.
// Depends on dlp_pkg for the result type and the queue depth.
module dlp_out_queue (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [1:0]                           push_cnt,
  input  dlp_pkg::res_t                        wr_a,
  input  dlp_pkg::res_t                        wr_b,
  output logic [$clog2(dlp_pkg::OQ_DEPTH+1)-1:0] free_cnt,
  output dlp_pkg::res_t                        rd_data,
  output logic                                 rd_valid,
  input  logic                                 rd_ready
);

  localparam int DEPTH = dlp_pkg::OQ_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dlp_pkg::res_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic             pop;

  assign wr_ptr_p1  = wr_ptr_r + 1'b1;
  assign pop        = rd_valid && rd_ready;
  assign rd_valid   = (cnt_r != '0);
  assign rd_data    = mem[rd_ptr_r];
  assign free_cnt   = CNT_W'(DEPTH) - cnt_r;
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign cnt_nxt    = cnt_r + CNT_W'(push_cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= wr_a;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/core/decimal_int16_list_parser.sv]
// Top level of the whitespace-separated decimal list parser.
// Depends on dlp_pkg, dlp_parse_core and dlp_out_queue.
//
// Usage: the bytes of a text string arrive one per beat on the in_ channel,
// with in_end_of_string high on the final byte. Every number closed by
// whitespace or by the end of the string leaves as a value beat on the out_
// channel; every string ends with one status beat (out_last_result high)
// that reports whether the string was well formed and held exactly
// expected_count numbers. The user must write the configuration registers
// expected_count (index 0) and signed_mode (index 1), through cfg_wr_en,
// cfg_index and cfg_wdata, only while the block is idle, which it does not enforce.
//
// Timing: an accepted byte waits in the input register and is parsed out of
// it once the result queue has room for all the results it may cause; the
// results go into the queue. One byte is taken every cycle while the queue
// has that room; the parse step is a multiply-by-ten, one add and one
// compare. A final byte that closes a number yields two results, and the
// queue drains one per cycle while out_ready is high, which bounds the
// long-run rate by the output side. Reset clears the parse state, the queue
// and both registers to zero. When the receiver stalls, results collect in
// the four-entry queue, and once it has fewer than two free entries the
// input register holds and in_ready falls.
module decimal_int16_list_parser #(
  parameter int MAX_STRING_BYTES = dlp_pkg::DEF_MAX_STRING_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_string,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_item_kind,
  output logic [3:0]  out_value_index,
  output logic [15:0] out_value_word,
  output logic        out_parse_status,
  output logic [4:0]  out_values_found,
  output logic        out_last_result,
  // Configuration port
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata
);

  localparam int OQ_CNT_W = $clog2(dlp_pkg::OQ_DEPTH + 1);

  dlp_pkg::cfg_t       cfg_r;
  logic                in_vld_r;
  logic [7:0]          in_byte_r;
  logic                in_eos_r;
  logic                fire;
  logic [1:0]          push_cnt;
  dlp_pkg::res_t       res_a;
  dlp_pkg::res_t       res_b;
  dlp_pkg::res_t       out_res;
  logic [OQ_CNT_W-1:0] oq_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dlp_pkg::REG_EXPECTED_COUNT: cfg_r.expected_count <= cfg_wdata;
        dlp_pkg::REG_SIGNED_MODE:    cfg_r.signed_mode    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The held byte is parsed only when the queue can take every result it
  // may cause, so a beat is never split across cycles.
  assign fire     = in_vld_r && (oq_free >= OQ_CNT_W'(dlp_pkg::MAX_RESULTS));
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_char_byte;
      in_eos_r  <= in_end_of_string;
    end
  end

  dlp_parse_core #(
    .MAX_STRING_BYTES(MAX_STRING_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .fire         (fire),
    .char_byte    (in_byte_r),
    .end_of_string(in_eos_r),
    .push_cnt     (push_cnt),
    .res_a        (res_a),
    .res_b        (res_b)
  );

  dlp_out_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_cnt(push_cnt),
    .wr_a    (res_a),
    .wr_b    (res_b),
    .free_cnt(oq_free),
    .rd_data (out_res),
    .rd_valid(out_valid),
    .rd_ready(out_ready)
  );

  assign out_item_kind    = out_res.item_kind;
  assign out_value_index  = out_res.value_index;
  assign out_value_word   = out_res.value_word;
  assign out_parse_status = out_res.parse_status;
  assign out_values_found = out_res.values_found;
  assign out_last_result  = out_res.last_result;

  // The final byte of a string always yields at least its status result.
  a_eos_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_eos_r |-> push_cnt != 2'd0)
    else $error("final byte produced no result");

  // Nothing enters the queue unless a byte is parsed.
  a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |-> push_cnt == 2'd0)
    else $error("result pushed without a parsed byte");

  // A byte that could not be parsed stays in the input register.
  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !fire |=> in_vld_r && $stable(in_byte_r) && $stable(in_eos_r))
    else $error("stalled input byte was lost or changed");

endmodule

[tb/decimal_int16_list_parser_tb.sv]
// Self-checking testbench for decimal_int16_list_parser: directed strings, then random
// text strings under three idling profiles, checked against an in-bench parse predictor.
// Depends on dlp_pkg and the decimal_int16_list_parser RTL; reads no files.
module decimal_int16_list_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Verdict codes carried in parse_status of a status beat.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Spare wait after the last expected result, to cover a byte that causes
  // nothing but is still inside the pipe.
  localparam int          DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Each configuration segment sends whole strings until it has used this many bytes.
  localparam int          SEGMENT_BYTES = 85;
  localparam int          SEGMENTS      = 6;

  // Results typed into the directed plan for one byte; n_typed < 0 leaves the
  // expectation to the predictor.
  typedef struct {
    int            n_typed;
    dlp_pkg::res_t first;
    dlp_pkg::res_t second;
  } typed_note_t;

  // One row of the directed plan: either a register write or one byte.
  typedef struct {
    bit          is_cfg;
    logic        reg_idx;
    logic [4:0]  reg_data;
    logic [7:0]  ch;
    logic        eos;
    typed_note_t note;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_byte = '0;
  logic        in_end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_item_kind;
  logic [3:0]  out_value_index;
  logic [15:0] out_value_word;
  logic        out_parse_status;
  logic [4:0]  out_values_found;
  logic        out_last_result;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = dlp_pkg::REG_EXPECTED_COUNT;
  logic [4:0]  cfg_wdata = '0;

  decimal_int16_list_parser dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Percent of cycles in which the sender holds back a beat and the receiver
  // drops ready. Changed only by the stimulus process between phases.
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // Expected result beats, oldest first, and the typed notes of bytes that
  // have been driven but not yet taken.
  dlp_pkg::res_t results_due[$];
  typed_note_t   hand_typed[$];

  // Text of the string being sent.
  logic [7:0]  text_q[$];
  plan_row_t   plan[$];

  // ---------------------------------------------------------------------------
  // Parse predictor. Holds its own copy of both registers and of the string
  // state; everything starts at zero, which is also the state after reset.
  // ---------------------------------------------------------------------------
  int unsigned want_count;
  bit          signed_on;
  bit          num_open;
  bit          minus_pending;
  bit          halted;
  bit          bad_string;
  int unsigned digits;
  int unsigned mag;
  int unsigned nums_started;
  int unsigned bytes_seen;

  function automatic dlp_pkg::res_t value_item(logic [3:0] idx, logic [15:0] word);
    dlp_pkg::res_t r;
    r             = '0;
    r.item_kind   = dlp_pkg::KIND_VALUE;
    r.value_index = idx;
    r.value_word  = word;
    return r;
  endfunction

  function automatic dlp_pkg::res_t status_item(logic verdict, logic [4:0] found);
    dlp_pkg::res_t r;
    r              = '0;
    r.item_kind    = dlp_pkg::KIND_STATUS;
    r.parse_status = verdict;
    r.values_found = found;
    r.last_result  = 1'b1;
    return r;
  endfunction

  // The number that whitespace or the end of the string has just closed.
  function automatic dlp_pkg::res_t closed_value();
    logic [15:0] word;
    word = mag[15:0];
    if (signed_on && minus_pending) word = -word;
    return value_item(4'(nums_started - 1), word);
  endfunction

  // Marks the string invalid; the rest of it is skipped up to its last byte.
  function automatic void abandon_string();
    bad_string = 1'b1;
    halted     = 1'b1;
  endfunction

  // Advances the predictor by one accepted byte and returns the results that
  // byte causes, in order.
  function automatic void parse_byte(input logic [7:0] ch, input logic last,
                                     output int n, output dlp_pkg::res_t first,
                                     output dlp_pkg::res_t second);
    dlp_pkg::res_t made [2];
    int unsigned   limit;
    int unsigned   cap;
    int unsigned   digit;
    bit            accept;
    n       = 0;
    made[0] = '0;
    made[1] = '0;
    if (!halted) begin
      if (bytes_seen < dlp_pkg::DEF_MAX_STRING_BYTES) bytes_seen++;
      else abandon_string();
    end
    if (!halted) begin
      limit = signed_on ? dlp_pkg::LIMIT_SIGNED : dlp_pkg::LIMIT_UNSIGNED;
      if (ch >= dlp_pkg::CHAR_ZERO && ch <= dlp_pkg::CHAR_NINE) begin
        digit  = ch - dlp_pkg::CHAR_ZERO;
        accept = 1'b1;
        if (!num_open) begin
          // A number that would exceed the list limit is counted but not parsed.
          cap      = (want_count < dlp_pkg::MAX_VALUES) ? want_count : dlp_pkg::MAX_VALUES;
          num_open = 1'b1;
          digits   = 0;
          mag      = 0;
          nums_started++;
          if (nums_started > cap) begin
            abandon_string();
            accept = 1'b0;
          end
        end
        if (accept) begin
          digits++;
          if (digits > dlp_pkg::MAX_DIGITS || mag * 10 > limit ||
              limit - mag * 10 < digit) begin
            abandon_string();
          end else begin
            mag = mag * 10 + digit;
          end
        end
      end else if (ch == dlp_pkg::CHAR_SPACE ||
                   (ch >= dlp_pkg::CHAR_TAB && ch <= dlp_pkg::CHAR_CR)) begin
        // Whitespace after a lone minus stops the string without flagging it.
        if (signed_on && !num_open && minus_pending) begin
          halted = 1'b1;
        end else begin
          if (num_open) begin
            made[n] = closed_value();
            n++;
          end
          num_open      = 1'b0;
          minus_pending = 1'b0;
        end
      end else if (signed_on && ch == dlp_pkg::CHAR_MINUS && !num_open &&
                   !minus_pending) begin
        minus_pending = 1'b1;
      end else begin
        abandon_string();
      end
    end
    if (last) begin
      if (!halted && num_open) begin
        made[n] = closed_value();
        n++;
      end
      made[n] = status_item((bad_string || nums_started != want_count) ? STATUS_BAD : STATUS_OK,
                            5'(nums_started));
      n++;
      num_open      = 1'b0;
      minus_pending = 1'b0;
      digits        = 0;
      mag           = 0;
      nums_started  = 0;
      bytes_seen    = 0;
      halted        = 1'b0;
      bad_string    = 1'b0;
    end
    first  = made[0];
    second = made[1];
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors. Both channels are sampled at the rising edge, before anything
  // driven at that edge takes effect, so a beat is seen exactly when the DUT
  // takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : track
    typed_note_t   note;
    dlp_pkg::res_t got0;
    dlp_pkg::res_t got1;
    dlp_pkg::res_t want;
    int            n;
    if (rst_n && in_valid && in_ready) begin
      note = hand_typed.pop_front();
      parse_byte(in_char_byte, in_end_of_string, n, got0, got1);
      // A directed byte with typed results is held to those instead; the
      // predictor still runs so that its state keeps up.
      if (note.n_typed >= 0) begin
        n    = note.n_typed;
        got0 = note.first;
        got1 = note.second;
      end
      if (n > 0) results_due.push_back(got0);
      if (n > 1) results_due.push_back(got1);
    end
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected: kind %0d, word %h",
               out_item_kind, out_value_word);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("item_kind", want.item_kind, out_item_kind);
        check_field("value_index", want.value_index, out_value_index);
        check_field("value_word", want.value_word, out_value_word);
        check_field("parse_status", want.parse_status, out_parse_status);
        check_field("values_found", want.values_found, out_values_found);
        check_field("last_result", want.last_result, out_last_result);
      end
    end
  end

  // The receiver drops ready at random, per cycle, at the current rate.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving. Every task returns at a rising edge; each signal gets at most one
  // nonblocking assignment per edge.
  // ---------------------------------------------------------------------------

  // Offers one byte, after a random hold-off, and returns at the edge where
  // it is taken. Valid and payload stay put until then.
  task automatic send_byte(input logic [7:0] ch, input logic last, input typed_note_t note);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    hand_typed.push_back(note);
    in_valid         <= 1'b1;
    in_char_byte     <= ch;
    in_end_of_string <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sends the whole text buffer as one string, back to back with the previous one.
  task automatic send_text();
    typed_note_t note;
    note.n_typed = -1;
    note.first   = '0;
    note.second  = '0;
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1, note);
  endtask

  // Stops sending and waits until every expected result has come out, plus a
  // spare wait for bytes that cause none. Only after this may a register change.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == dlp_pkg::REG_EXPECTED_COUNT) want_count = data;
    else signed_on = data[0];
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan building.
  // ---------------------------------------------------------------------------
  task automatic plan_reg(input logic idx, input logic [4:0] data);
    plan_row_t row;
    row          = '{default: '0};
    row.is_cfg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    plan.push_back(row);
  endtask

  // One string; the typed results, if any, belong to its last byte.
  task automatic plan_text(input string s, input int n_typed, input dlp_pkg::res_t first,
                           input dlp_pkg::res_t second);
    plan_row_t row;
    foreach (s[i]) begin
      row              = '{default: '0};
      row.ch           = s[i];
      row.eos          = (i == s.len() - 1);
      row.note.n_typed = row.eos ? n_typed : -1;
      row.note.first   = first;
      row.note.second  = second;
      plan.push_back(row);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random string building. All of it appends to text_q.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_space();
    if ($urandom_range(2) == 0) return dlp_pkg::CHAR_SPACE;
    return dlp_pkg::CHAR_TAB + 8'($urandom_range(4));
  endfunction

  task automatic add_gap();
    repeat ($urandom_range(1, 3)) text_q.push_back(pick_space());
  endtask

  // One number: mostly in range with the extremes often, and when wild also
  // overflowing magnitudes and a sixth digit through a leading zero.
  task automatic add_number(input bit wild);
    int unsigned limit;
    int unsigned m;
    int          pad;
    string       s;
    limit = signed_on ? dlp_pkg::LIMIT_SIGNED : dlp_pkg::LIMIT_UNSIGNED;
    case ($urandom_range(5))
      0: m = limit;
      1: m = 0;
      2: m = $urandom_range(9);
      5: m = !wild ? $urandom_range(999) :
             ($urandom_range(1) == 0) ? limit + 1 : $urandom_range(limit + 1, 99999);
      default: m = $urandom_range(limit);
    endcase
    if (signed_on && $urandom_range(1) == 0) text_q.push_back(dlp_pkg::CHAR_MINUS);
    s   = $sformatf("%0d", m);
    pad = 0;
    if ($urandom_range(5) == 0) pad = dlp_pkg::MAX_DIGITS - s.len();
    if (wild && $urandom_range(2) == 0) pad++;
    repeat (pad) text_q.push_back(dlp_pkg::CHAR_ZERO);
    foreach (s[i]) text_q.push_back(s[i]);
  endtask

  // A well-formed list, usually with the register's count of numbers, now and
  // then one more or one fewer, or any count up to one past the value limit.
  task automatic build_list();
    int count;
    bit wild;
    wild = ($urandom_range(7) == 0);
    case ($urandom_range(9))
      7:       count = want_count + 1;
      8:       count = (want_count > 0) ? want_count - 1 : 0;
      9:       count = $urandom_range(dlp_pkg::MAX_VALUES + 1);
      default: count = want_count;
    endcase
    if ($urandom_range(3) == 0) add_gap();
    for (int i = 0; i < count; i++) begin
      if (i != 0) add_gap();
      add_number(wild);
    end
    if ($urandom_range(3) == 0) add_gap();
    // Every beat carries a byte, so a string cannot be empty.
    if (text_q.size() == 0) text_q.push_back(pick_space());
  endtask

  task automatic make_string();
    int pick;
    int pos;
    text_q.delete();
    pick = $urandom_range(99);
    if (pick < 65) begin
      build_list();
    end else if (pick < 85) begin
      // A good list with one flaw: a stray byte, an extra minus, a lone minus
      // followed by whitespace, or a string cut short.
      build_list();
      pos = $urandom_range(text_q.size() - 1);
      case ($urandom_range(3))
        0: text_q[pos] = 8'($urandom_range(255));
        1: text_q.insert(pos, dlp_pkg::CHAR_MINUS);
        2: begin
          text_q.insert(pos, pick_space());
          text_q.insert(pos, dlp_pkg::CHAR_MINUS);
        end
        default: while (text_q.size() > pos + 1) void'(text_q.pop_back());
      endcase
    end else begin
      // Short noise made of digits, whitespace, minus signs and any byte.
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(3))
          0:       text_q.push_back(dlp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
          1:       text_q.push_back(pick_space());
          2:       text_q.push_back(dlp_pkg::CHAR_MINUS);
          default: text_q.push_back(8'($urandom_range(255)));
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned corner_counts [SEGMENTS];
    bit          corner_signs [SEGMENTS];
    int unsigned count;
    bit          sgn;
    int          seg_bytes;
    corner_counts = '{0, 16, 1, 16, 0, 2};
    corner_signs  = '{0, 1, 1, 0, 1, 0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first two strings run with the reset values of the
    // registers: no numbers expected, unsigned.
    plan_text("\015", 1, status_item(STATUS_OK, 5'd0), '0);
    plan_text("\377", 1, status_item(STATUS_BAD, 5'd0), '0);
    // Unsigned extremes: the largest value, then zero closed by the end of
    // the string, so the last byte yields a value beat and the status beat.
    plan_reg(dlp_pkg::REG_EXPECTED_COUNT, 5'd2);
    plan_text("65535\t0", 2, value_item(4'd1, 16'd0), status_item(STATUS_OK, 5'd2));
    // One past the unsigned limit: the open number is dropped.
    plan_text("65536", 1, status_item(STATUS_BAD, 5'd1), '0);
    plan_reg(dlp_pkg::REG_SIGNED_MODE, 5'd1);
    plan_reg(dlp_pkg::REG_EXPECTED_COUNT, 5'd1);
    // Most negative value that signed mode accepts.
    plan_text("-32767", 2, value_item(4'd0, 16'h8001), status_item(STATUS_OK, 5'd1));
    // Whitespace after a lone minus stops parsing; only the count decides.
    plan_text("- ", 1, status_item(STATUS_BAD, 5'd0), '0);
    // A second number when one is expected is counted and flags the string.
    plan_text("1 2", 1, status_item(STATUS_BAD, 5'd2), '0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_byte(plan[i].ch, plan[i].eos, plan[i].note);
      end
    end

    // Random part: three idling profiles, each walking several register
    // settings. The first profile uses the corner settings, the others draw
    // them at random with the extremes favored.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  = 18;
          out_idle_pct = 74;
        end
        1: begin
          in_idle_pct  = 74;
          out_idle_pct = 18;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        if (phase == 0) begin
          count = corner_counts[seg];
          sgn   = corner_signs[seg];
        end else begin
          case ($urandom_range(5))
            0:       count = 0;
            1:       count = 1;
            2:       count = dlp_pkg::MAX_VALUES;
            default: count = $urandom_range(2, dlp_pkg::MAX_VALUES - 1);
          endcase
          sgn = $urandom_range(1);
        end
        drain();
        write_reg(dlp_pkg::REG_EXPECTED_COUNT, 5'(count));
        write_reg(dlp_pkg::REG_SIGNED_MODE, {4'b0, sgn});
        seg_bytes = 0;
        while (seg_bytes < SEGMENT_BYTES) begin
          make_string();
          seg_bytes += text_q.size();
          send_text();
        end
      end
    end

    // String length limit, sent without idling: the byte at the maximum
    // length still starts a number, and the one byte more flags the string
    // and drops the number it would have extended.
    drain();
    write_reg(dlp_pkg::REG_EXPECTED_COUNT, 5'd1);
    write_reg(dlp_pkg::REG_SIGNED_MODE, {4'b0, 1'($urandom_range(1))});
    text_q.delete();
    repeat (dlp_pkg::DEF_MAX_STRING_BYTES - 1) text_q.push_back(pick_space());
    text_q.push_back(dlp_pkg::CHAR_ZERO + 8'd1);
    text_q.push_back(dlp_pkg::CHAR_ZERO + 8'd2);
    send_text();

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/dlp_pkg.sv
rtl/core/dlp_parse_core.sv
rtl/core/dlp_out_queue.sv
rtl/core/decimal_int16_list_parser.sv
tb/decimal_int16_list_parser_tb.sv
